/* src/vcfgt_pkg.sv */
// ----------------------------------------------------------------------------
// vcfgt_pkg
// Shared types and constants for the VCF genotype stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package vcfgt_pkg;

	// default parameter values
	localparam int unsigned DEF_MAX_SAMPLES   = 65536;
	localparam logic [3:0]  DEF_MISSING_CODE  = 4'd15;
	localparam int unsigned DEF_POSITION_BITS = 32;

	// characters of the text stream
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_BAR   = 8'h7C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// two-character tag "GT"
	localparam logic [15:0] TAG_GT  = 16'h4754;
	// gt tag index when FORMAT has no GT
	localparam logic [8:0]  GT_NONE = 9'd256;

	// tab-separated field numbers
	localparam logic [3:0] FIELD_POS    = 4'd1;
	localparam logic [3:0] FIELD_ALT    = 4'd4;
	localparam logic [3:0] FIELD_FORMAT = 4'd8;
	localparam logic [3:0] FIELD_SAMPLE = 4'd9;

	// configuration register indexes
	localparam logic CFG_SAMPLE_COUNT = 1'b0;
	localparam logic CFG_GENOTYPES    = 1'b1;

	// line mode
	typedef enum logic [1:0] {
		MODE_START  = 2'd0,
		MODE_SKIP   = 2'd1,
		MODE_RECORD = 2'd2
	} mode_t;

	// separator tracking inside a GT subfield
	typedef enum logic [1:0] {
		SEP_WAIT    = 2'd0,
		SEP_SEEN    = 2'd1,
		SEP_DONE    = 2'd2,
		SEP_MISSING = 2'd3
	} sep_t;

	// one result item
	typedef struct packed {
		logic        kind;
		logic [15:0] sample_index;
		logic [3:0]  allele_first;
		logic [3:0]  allele_second;
		logic [31:0] position;
		logic [7:0]  alt_count;
		logic        line_valid;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

/* src/vcf_genotype_stream_parser_core.sv */
// ----------------------------------------------------------------------------
// vcf_genotype_stream_parser_core
// Byte-wide VCF record parser giving per-sample genotypes and line summaries.
// ----------------------------------------------------------------------------
// Takes one text byte per beat and accepts a byte in every cycle in which the
// input is not stalled. A byte goes through an input register, is parsed
// combinationally against the running line state and leaves 0, 1 or 2 results
// in a four-entry result queue, from which the output port reads. The output
// port moves one result per cycle while m_tready is high: bytes run at one per
// cycle as long as they average no more than one result each, and a byte that
// gives both a genotype and a line summary puts two results into the queue.
// The input stalls only while the queue holds more than two results.
`default_nettype none

module vcf_genotype_stream_parser_core #(
	parameter int unsigned MAX_SAMPLES   = vcfgt_pkg::DEF_MAX_SAMPLES,
	parameter logic [3:0]  MISSING_CODE  = vcfgt_pkg::DEF_MISSING_CODE,
	parameter int unsigned POSITION_BITS = vcfgt_pkg::DEF_POSITION_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// text input
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // data_byte
	input  wire logic        s_tlast,   // chunk_end
	// results
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // sample_index[15:0], allele_first[19:16],
	                                    // allele_second[23:20], position[55:24],
	                                    // alt_count[63:56], line_valid[64], zeros
	output logic [0:0]       m_tuser,   // record_kind
	output logic             m_tlast,   // last_of_run
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [16:0] cfg_data
);
	import vcfgt_pkg::*;

	localparam int SW = $clog2(MAX_SAMPLES + 1);
	localparam int PW = POSITION_BITS;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	// configuration registers
	logic [16:0] cfg_count_q;
	logic        cfg_geno_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_count_q <= 17'd1;
			cfg_geno_q  <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SAMPLE_COUNT: cfg_count_q <= cfg_data;
				CFG_GENOTYPES:    cfg_geno_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective sample count, limited to the supported maximum
	logic [SW-1:0] eff_count;
	assign eff_count = (32'(cfg_count_q) > 32'(MAX_SAMPLES)) ? SW'(MAX_SAMPLES)
	                                                        : SW'(cfg_count_q);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       go;

	// result queue
	result_t         queue_q [QDEPTH];
	logic [QAW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QAW:0]    count_q;
	logic            pop;

	assign go       = valid_s1 && (count_q <= (QAW+1)'(QDEPTH - 2));
	assign s_tready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	// parse state
	mode_t          mode_q,       mode_n;
	logic [3:0]     field_q,      field_n;
	logic [PW-1:0]  pos_q,        pos_n;
	logic [7:0]     alt_q,        alt_n;
	logic           alt_seen_q,   alt_seen_n;
	logic [7:0]     fmt_idx_q,    fmt_idx_n;
	logic [15:0]    tag_chars_q,  tag_chars_n;
	logic [1:0]     tag_len_q,    tag_len_n;
	logic [8:0]     gt_idx_q,     gt_idx_n;
	logic [SW-1:0]  seen_q,       seen_n;
	logic [7:0]     sub_q,        sub_n;
	logic           gt_pos_q,     gt_pos_n;
	logic [3:0]     gt_first_q,   gt_first_n;
	logic [3:0]     gt_second_q,  gt_second_n;
	sep_t           gt_sep_q,     gt_sep_n;
	logic           has_chars_q,  has_chars_n;

	logic           geno_emit, sum_emit;
	result_t        geno_res, sum_res;
	logic [1:0]     npush;

	// one byte of parsing
	always_comb begin
		logic       c_nl, c_tab, c_digit, finish, stop, in_samples, do_close;
		logic [7:0] c;
		logic [63:0] pos_wide;

		c        = byte_s1;
		c_nl     = (c == CH_NL);
		c_tab    = (c == CH_TAB);
		c_digit  = (c inside {[CH_ZERO:CH_NINE]});
		finish   = c_nl || end_s1;
		stop     = 1'b0;
		do_close = 1'b0;

		mode_n      = mode_q;
		field_n     = field_q;
		pos_n       = pos_q;
		alt_n       = alt_q;
		alt_seen_n  = alt_seen_q;
		fmt_idx_n   = fmt_idx_q;
		tag_chars_n = tag_chars_q;
		tag_len_n   = tag_len_q;
		gt_idx_n    = gt_idx_q;
		seen_n      = seen_q;
		sub_n       = sub_q;
		gt_pos_n    = gt_pos_q;
		gt_first_n  = gt_first_q;
		gt_second_n = gt_second_q;
		gt_sep_n    = gt_sep_q;
		has_chars_n = has_chars_q;
		geno_emit   = 1'b0;
		sum_emit    = 1'b0;
		geno_res    = '0;
		sum_res     = '0;

		// line start: skip blank, enter header or record
		if (mode_q == MODE_START) begin
			if (c_nl) begin
				stop = 1'b1;
			end else if (c == CH_HASH) begin
				mode_n = MODE_SKIP;
			end else begin
				mode_n      = MODE_RECORD;
				field_n     = '0;
				pos_n       = '0;
				alt_n       = '0;
				fmt_idx_n   = '0;
				gt_idx_n    = GT_NONE;
				seen_n      = '0;
				alt_seen_n  = 1'b0;
				tag_chars_n = '0;
				tag_len_n   = '0;
				sub_n       = '0;
				has_chars_n = 1'b0;
				gt_pos_n    = 1'b0;
				gt_sep_n    = SEP_WAIT;
				gt_first_n  = MISSING_CODE;
				gt_second_n = MISSING_CODE;
			end
		end

		// header line
		if (!stop && mode_n == MODE_SKIP) begin
			if (finish) mode_n = MODE_START;
			stop = 1'b1;
		end

		in_samples = (field_n >= FIELD_SAMPLE) && (seen_n < eff_count);

		// ordinary character inside a field
		if (!stop && !c_nl && !c_tab) begin
			has_chars_n = 1'b1;
			if (field_n == FIELD_POS) begin
				pos_n = (pos_n << 3) + (pos_n << 1) + PW'(c) - PW'(CH_ZERO);
			end else if (field_n == FIELD_ALT) begin
				if (c == CH_COMMA) begin
					if (alt_n != 8'hFF) alt_n = alt_n + 8'd1;
					alt_seen_n = 1'b0;
				end else begin
					alt_seen_n = 1'b1;
				end
			end else if (field_n == FIELD_FORMAT) begin
				if (c == CH_COLON) begin
					if (tag_len_n == 2'd2 && tag_chars_n == TAG_GT && fmt_idx_n != 8'hFF)
						gt_idx_n = {1'b0, fmt_idx_n};
					if (fmt_idx_n != 8'hFF) fmt_idx_n = fmt_idx_n + 8'd1;
					tag_chars_n = '0;
					tag_len_n   = '0;
				end else begin
					if (tag_len_n < 2'd2) tag_chars_n = {tag_chars_n[7:0], c};
					if (tag_len_n != 2'd3) tag_len_n = tag_len_n + 2'd1;
				end
			end else if (in_samples) begin
				if (c == CH_COLON) begin
					if (sub_n != 8'hFF) sub_n = sub_n + 8'd1;
					if ({1'b0, sub_n} == gt_idx_n) begin
						gt_pos_n    = 1'b0;
						gt_sep_n    = SEP_WAIT;
						gt_first_n  = MISSING_CODE;
						gt_second_n = MISSING_CODE;
					end
				end else if ({1'b0, sub_n} == gt_idx_n && gt_sep_n != SEP_MISSING) begin
					// genotype text: allele, separator, allele
					if (!gt_pos_n) begin
						if (c == CH_DOT) gt_sep_n = SEP_MISSING;
						else if (c_digit) gt_first_n = 4'(c - CH_ZERO);
						gt_pos_n = 1'b1;
					end else if (gt_sep_n == SEP_WAIT) begin
						if (c == CH_SLASH || c == CH_BAR) gt_sep_n = SEP_SEEN;
					end else if (gt_sep_n == SEP_SEEN) begin
						if (c_digit) gt_second_n = 4'(c - CH_ZERO);
						gt_sep_n = SEP_DONE;
					end
				end
			end
		end

		// field close on tab, or at line end when the field has characters
		if (!stop) do_close = c_tab || (finish && has_chars_n);
		if (do_close) begin
			if (field_n == FIELD_ALT) begin
				if (alt_seen_n && alt_n != 8'hFF) alt_n = alt_n + 8'd1;
			end else if (field_n == FIELD_FORMAT) begin
				if (tag_len_n == 2'd2 && tag_chars_n == TAG_GT && fmt_idx_n != 8'hFF)
					gt_idx_n = {1'b0, fmt_idx_n};
			end else if (in_samples) begin
				geno_emit                = cfg_geno_q;
				geno_res.kind            = 1'b0;
				geno_res.sample_index    = 16'(seen_n);
				geno_res.allele_first    = gt_first_n;
				geno_res.allele_second   = gt_second_n;
				seen_n                   = seen_n + SW'(1);
			end
			if (field_n < FIELD_SAMPLE) field_n = field_n + 4'd1;
			alt_seen_n  = 1'b0;
			tag_chars_n = '0;
			tag_len_n   = '0;
			sub_n       = '0;
			has_chars_n = 1'b0;
			gt_pos_n    = 1'b0;
			gt_sep_n    = SEP_WAIT;
			gt_first_n  = MISSING_CODE;
			gt_second_n = MISSING_CODE;
		end

		// line summary
		pos_wide = 64'(pos_n);
		if (!stop && finish) begin
			sum_emit           = 1'b1;
			sum_res.kind       = 1'b1;
			sum_res.position   = pos_wide[31:0];
			sum_res.alt_count  = alt_n;
			sum_res.line_valid = (seen_n == eff_count);
			sum_res.last       = 1'b1;
			mode_n             = MODE_START;
		end
		geno_res.last = !sum_emit;
		npush = {1'b0, geno_emit} + {1'b0, sum_emit};
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_START;
			field_q     <= '0;
			pos_q       <= '0;
			alt_q       <= '0;
			alt_seen_q  <= 1'b0;
			fmt_idx_q   <= '0;
			tag_chars_q <= '0;
			tag_len_q   <= '0;
			gt_idx_q    <= GT_NONE;
			seen_q      <= '0;
			sub_q       <= '0;
			gt_pos_q    <= 1'b0;
			gt_first_q  <= MISSING_CODE;
			gt_second_q <= MISSING_CODE;
			gt_sep_q    <= SEP_WAIT;
			has_chars_q <= 1'b0;
		end else if (go) begin
			mode_q      <= mode_n;
			field_q     <= field_n;
			pos_q       <= pos_n;
			alt_q       <= alt_n;
			alt_seen_q  <= alt_seen_n;
			fmt_idx_q   <= fmt_idx_n;
			tag_chars_q <= tag_chars_n;
			tag_len_q   <= tag_len_n;
			gt_idx_q    <= gt_idx_n;
			seen_q      <= seen_n;
			sub_q       <= sub_n;
			gt_pos_q    <= gt_pos_n;
			gt_first_q  <= gt_first_n;
			gt_second_q <= gt_second_n;
			gt_sep_q    <= gt_sep_n;
			has_chars_q <= has_chars_n;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (go) begin
			if (geno_emit) begin
				queue_q[wr_ptr_q] <= geno_res;
				if (sum_emit) queue_q[wr_ptr_q + QAW'(1)] <= sum_res;
			end else if (sum_emit) begin
				queue_q[wr_ptr_q] <= sum_res;
			end
		end
	end

	// result queue pointers
	assign pop = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (go) wr_ptr_q <= wr_ptr_q + QAW'(npush);
			if (pop) rd_ptr_q <= rd_ptr_q + QAW'(1);
			count_q <= count_q + (go ? (QAW+1)'(npush) : '0) - (QAW+1)'(pop);
		end
	end

	// output beat
	result_t head;
	assign head     = queue_q[rd_ptr_q];
	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {7'd0, head.line_valid, head.alt_count, head.position,
	                   head.allele_second, head.allele_first, head.sample_index};
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;

`ifndef ASSERT_OFF
	// queue never holds more than its depth
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW+1)'(QDEPTH))
		else $error("result queue overflow");

	// a line summary is always the last result of its byte
	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> m_tlast)
		else $error("summary without last flag");

	// field counter saturates at the first sample field
	a_field_sat: assert property (@(posedge clk) disable iff (!arst_n)
		field_q <= FIELD_SAMPLE)
		else $error("field counter out of range");
`endif

endmodule

`default_nettype wire

/* tb/vcf_genotype_stream_parser_core_test.sv */
// ----------------------------------------------------------------------------
// vcf_genotype_stream_parser_core_test
// Self-checking bench for the byte-wide VCF genotype parser.
// ----------------------------------------------------------------------------
// A short table of hand-made beats comes first, then random lines: mostly
// well-formed records with random content, plus header lines, empty lines,
// noise and oversized ALT and FORMAT fields. Every accepted byte is run
// through a behavioral parser kept here, and each result beat is compared
// field by field with the oldest outstanding prediction. Both handshakes
// idle in random bursts, and the register settings change between phases
// once the parser has drained.
// ----------------------------------------------------------------------------

module vcf_genotype_stream_parser_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import vcfgt_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_BYTES = 25;

	typedef struct packed {
		logic [7:0] c;
		logic       e;
	} beat_t;

	typedef struct {
		logic [7:0] c;
		logic       e;
		int         n_exp;   // -1: take the parser model's results
		result_t    x0;
		result_t    x1;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [16:0] cfg_data;

	// register copies
	logic [16:0] cfg_samples;
	logic        cfg_gen;

	// line parser state
	mode_t       line_state;
	int          col_no;
	logic [31:0] pos_sum;
	int          alt_n;
	logic        alt_text;
	int          fmt_tag;
	logic [15:0] tag_buf;
	int          tag_len;
	int          gt_col;
	int          samples_done;
	int          sub_no;
	int          allele_pos;
	logic [3:0]  first_al;
	logic [3:0]  second_al;
	sep_t        sep_state;
	logic        col_busy;

	result_t     step_out[$];
	result_t     pending_results[$];
	beat_t       line_q[$];
	dir_row_t    dir_tab[$];

	int          mismatches = 0;
	int          cycles = 0;
	int          sent_items = 0;
	bit          quiet_tail = 0;

	vcf_genotype_stream_parser_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// parser model
	// ------------------------------------------------------------------

	function automatic int live_samples();
		return (cfg_samples > DEF_MAX_SAMPLES) ? int'(DEF_MAX_SAMPLES) : int'(cfg_samples);
	endfunction

	function automatic bit is_dig(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic result_t geno_res(int idx, logic [3:0] a, logic [3:0] b);
		result_t r;
		r = '0;
		r.kind = 1'b0;
		r.sample_index = 16'(idx);
		r.allele_first = a;
		r.allele_second = b;
		return r;
	endfunction

	function automatic result_t line_res(logic [31:0] pos, int alt, bit ok, bit last);
		result_t r;
		r = '0;
		r.kind = 1'b1;
		r.position = pos;
		r.alt_count = 8'(alt);
		r.line_valid = ok;
		r.last = last;
		return r;
	endfunction

	function automatic void allele_reset();
		allele_pos = 0;
		sep_state = SEP_WAIT;
		first_al = DEF_MISSING_CODE;
		second_al = DEF_MISSING_CODE;
	endfunction

	function automatic void column_reset();
		alt_text = 1'b0;
		tag_buf = '0;
		tag_len = 0;
		sub_no = 0;
		col_busy = 1'b0;
		allele_reset();
	endfunction

	function automatic void record_begin();
		col_no = 0;
		pos_sum = '0;
		alt_n = 0;
		fmt_tag = 0;
		gt_col = int'(GT_NONE);
		samples_done = 0;
		column_reset();
	endfunction

	// a finished two-letter GT tag below index 255 is remembered
	function automatic void tag_commit();
		if (tag_len == 2 && tag_buf == TAG_GT && fmt_tag < 255)
			gt_col = fmt_tag;
	endfunction

	// allele digits and separator inside the GT subfield
	function automatic void allele_feed(logic [7:0] c);
		if (sep_state == SEP_MISSING)
			return;
		if (allele_pos == 0) begin
			if (c == CH_DOT)
				sep_state = SEP_MISSING;
			else if (is_dig(c))
				first_al = 4'(c - CH_ZERO);
			allele_pos = 1;
		end else if (sep_state == SEP_WAIT) begin
			if (c == CH_SLASH || c == CH_BAR)
				sep_state = SEP_SEEN;
		end else if (sep_state == SEP_SEEN) begin
			if (is_dig(c))
				second_al = 4'(c - CH_ZERO);
			sep_state = SEP_DONE;
		end
	endfunction

	function automatic void column_end();
		if (col_no == FIELD_ALT) begin
			if (alt_text && alt_n < 255)
				alt_n++;
		end else if (col_no == FIELD_FORMAT) begin
			tag_commit();
		end else if (col_no >= FIELD_SAMPLE && samples_done < live_samples()) begin
			if (cfg_gen)
				step_out = {step_out, geno_res(samples_done, first_al, second_al)};
			samples_done++;
		end
		if (col_no < FIELD_SAMPLE)
			col_no++;
		column_reset();
	endfunction

	function automatic void column_feed(logic [7:0] c);
		col_busy = 1'b1;
		if (col_no == FIELD_POS) begin
			pos_sum = pos_sum * 32'd10 + 32'(c) - 32'd48;
		end else if (col_no == FIELD_ALT) begin
			if (c == CH_COMMA) begin
				if (alt_n < 255)
					alt_n++;
				alt_text = 1'b0;
			end else begin
				alt_text = 1'b1;
			end
		end else if (col_no == FIELD_FORMAT) begin
			if (c == CH_COLON) begin
				tag_commit();
				if (fmt_tag < 255)
					fmt_tag++;
				tag_buf = '0;
				tag_len = 0;
			end else begin
				if (tag_len < 2)
					tag_buf = {tag_buf[7:0], c};
				if (tag_len < 3)
					tag_len++;
			end
		end else if (col_no >= FIELD_SAMPLE && samples_done < live_samples()) begin
			if (c == CH_COLON) begin
				if (sub_no < 255)
					sub_no++;
				if (sub_no == gt_col)
					allele_reset();
			end else if (sub_no == gt_col) begin
				allele_feed(c);
			end
		end
	endfunction

	function automatic void line_done();
		if (col_busy)
			column_end();
		step_out = {step_out, line_res(pos_sum, alt_n, samples_done == live_samples(), 1'b0)};
		line_state = MODE_START;
	endfunction

	// results caused by one accepted byte go to step_out
	function automatic void parse_byte(logic [7:0] c, logic e);
		result_t r;
		step_out.delete();
		if (line_state == MODE_START) begin
			if (c == CH_NL)
				return;
			if (c == CH_HASH) begin
				line_state = MODE_SKIP;
			end else begin
				record_begin();
				line_state = MODE_RECORD;
			end
		end
		if (line_state == MODE_SKIP) begin
			if (c == CH_NL || e)
				line_state = MODE_START;
			return;
		end
		if (c == CH_NL) begin
			line_done();
		end else begin
			if (c == CH_TAB)
				column_end();
			else
				column_feed(c);
			if (e)
				line_done();
		end
		if (step_out.size() != 0) begin
			r = step_out[step_out.size() - 1];
			r.last = 1'b1;
			step_out[step_out.size() - 1] = r;
		end
	endfunction

	// ------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------

	function automatic void check_eq(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing expected, expected none, got %h %h %b",
					$time, m_tuser, m_tdata, m_tlast);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_eq("record_kind", want.kind, m_tuser[0]);
				check_eq("sample_index", want.sample_index, m_tdata[15:0]);
				check_eq("allele_first", want.allele_first, m_tdata[19:16]);
				check_eq("allele_second", want.allele_second, m_tdata[23:20]);
				check_eq("position", want.position, m_tdata[55:24]);
				check_eq("alt_count", want.alt_count, m_tdata[63:56]);
				check_eq("line_valid", want.line_valid, m_tdata[64]);
				check_eq("tdata padding", '0, m_tdata[71:65]);
				check_eq("last_of_run", want.last, m_tlast);
			end
		end
	end

	// result side backpressure in bursts
	initial begin : ready_driver
		int n;
		bit rdy;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (quiet_tail) begin
				n = 1;
				rdy = 1'b1;
			end else begin
				n = $urandom_range(1, 17);
				rdy = $urandom_range(0, 2) != 0;
			end
			repeat (n) begin
				@(negedge clk);
				m_tready <= rdy;
			end
		end
	end

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------

	task automatic send_beat(input beat_t b, input bit gappy);
		int gap;
		@(negedge clk);
		if (gappy && !quiet_tail && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 17);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b.c;
		s_tlast <= b.e;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop sending and let every expected result come out
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [16:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_SAMPLE_COUNT)
			cfg_samples = val;
		else
			cfg_gen = val[0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_line();
		bit gappy;
		beat_t b;
		gappy = $urandom_range(0, 2) != 0;
		while (line_q.size() != 0) begin
			b = line_q.pop_front();
			send_beat(b, gappy);
			parse_byte(b.c, b.e);
			foreach (step_out[i])
				pending_results = {pending_results, step_out[i]};
			sent_items++;
		end
	endtask

	// ------------------------------------------------------------------
	// line builders
	// ------------------------------------------------------------------

	function automatic void put_ch(logic [7:0] c);
		beat_t b;
		b.c = c;
		b.e = 1'b0;
		line_q = {line_q, b};
	endfunction

	function automatic void put_str(string s);
		for (int i = 0; i < s.len(); i++)
			put_ch(s[i]);
	endfunction

	function automatic void end_chunk();
		beat_t b;
		if (line_q.size() == 0)
			return;
		b = line_q[line_q.size() - 1];
		b.e = 1'b1;
		line_q[line_q.size() - 1] = b;
	endfunction

	function automatic logic [7:0] digit_ch();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] sep_ch();
		return ($urandom_range(0, 1) != 0) ? CH_SLASH : CH_BAR;
	endfunction

	// text byte that is no separator for the parser: a digit, a letter or a high byte
	function automatic logic [7:0] plain_ch();
		case ($urandom_range(0, 3))
			0: return digit_ch();
			1: return 8'($urandom_range(8'h41, 8'h5A));
			2: return 8'($urandom_range(8'h61, 8'h7A));
			default: return 8'($urandom_range(8'h80, 8'hFF));
		endcase
	endfunction

	function automatic void put_plain(int lo, int hi);
		repeat ($urandom_range(lo, hi)) put_ch(plain_ch());
	endfunction

	function automatic void put_genotype();
		case ($urandom_range(0, 11))
			0, 1, 2, 3: begin
				put_ch(digit_ch()); put_ch(sep_ch()); put_ch(digit_ch());
			end
			4: put_ch(CH_DOT);
			5: begin
				put_ch(CH_DOT); put_ch(sep_ch()); put_ch(CH_DOT);
			end
			6: ;
			7: put_ch(digit_ch());
			8: begin
				put_ch(digit_ch()); put_ch(sep_ch()); put_ch(CH_DOT);
			end
			9: begin
				put_ch(plain_ch()); put_ch(sep_ch()); put_ch(digit_ch());
			end
			10: begin
				put_ch(digit_ch()); put_ch(digit_ch()); put_ch(sep_ch()); put_ch(digit_ch());
			end
			default: begin
				put_ch(digit_ch()); put_ch(sep_ch());
				if ($urandom_range(0, 1) != 0)
					put_ch(sep_ch());
				put_ch(digit_ch()); put_ch(sep_ch()); put_ch(digit_ch());
			end
		endcase
	endfunction

	// well-formed record with random content and a random ending
	function automatic void build_record();
		string tags[$];
		string pool[8];
		int nsamp;
		int nsub;
		int live;
		pool = '{"GT", "DS", "GP", "G", "T", "GTA", "AD", ""};
		put_plain(0, 3);
		put_ch(CH_TAB);
		// position, sometimes long enough to wrap or with junk in it
		case ($urandom_range(0, 19))
			0: ;
			1, 2: repeat ($urandom_range(10, 12)) put_ch(digit_ch());
			3, 4: repeat ($urandom_range(1, 4)) put_ch(($urandom_range(0, 1) != 0) ?
				digit_ch() : plain_ch());
			default: repeat ($urandom_range(1, 9)) put_ch(digit_ch());
		endcase
		put_ch(CH_TAB);
		put_plain(0, 2);
		put_ch(CH_TAB);
		put_plain(1, 3);
		put_ch(CH_TAB);
		// alt entries, empty ones included
		repeat ($urandom_range(0, 4)) begin
			put_plain(0, 2);
			put_ch(CH_COMMA);
		end
		put_plain(0, 2);
		repeat (3) begin
			put_ch(CH_TAB);
			put_plain(0, 2);
		end
		put_ch(CH_TAB);
		// format tags, GT most of the time, sometimes twice
		repeat ($urandom_range(0, 4)) tags = {tags, pool[$urandom_range(0, 7)]};
		if ($urandom_range(0, 3) != 0)
			tags.insert($urandom_range(0, tags.size()), "GT");
		foreach (tags[i]) begin
			if (i > 0)
				put_ch(CH_COLON);
			put_str(tags[i]);
		end
		// sample columns around the configured count when it is at most four, else zero to four
		live = live_samples();
		if (live <= 4)
			nsamp = live + int'($urandom_range(0, 3)) - 1;
		else
			nsamp = $urandom_range(0, 4);
		for (int s = 0; s < nsamp; s++) begin
			put_ch(CH_TAB);
			nsub = tags.size();
			if ($urandom_range(0, 4) == 0)
				nsub = nsub + int'($urandom_range(0, 2)) - 1;
			for (int j = 0; j < nsub; j++) begin
				if (j > 0)
					put_ch(CH_COLON);
				if (j < tags.size() && tags[j] == "GT")
					put_genotype();
				else
					put_plain(0, 2);
			end
		end
		case ($urandom_range(0, 19))
			14, 15: begin
				put_ch(CH_TAB); put_ch(CH_NL);
			end
			16, 17: end_chunk();
			18, 19: begin
				nsub = $urandom_range(1, line_q.size());
				while (line_q.size() > nsub) void'(line_q.pop_back());
				end_chunk();
			end
			default: put_ch(CH_NL);
		endcase
	endfunction

	function automatic void build_header();
		logic [7:0] c;
		put_ch(CH_HASH);
		repeat ($urandom_range(0, 8)) begin
			c = 8'($urandom_range(0, 255));
			put_ch((c == CH_NL) ? CH_HASH : c);
		end
		if ($urandom_range(0, 2) == 0)
			end_chunk();
		else
			put_ch(CH_NL);
	endfunction

	function automatic void build_noise();
		beat_t b;
		repeat ($urandom_range(1, 20)) begin
			case ($urandom_range(0, 11))
				6: b.c = CH_TAB;
				7: b.c = CH_NL;
				8: b.c = CH_COLON;
				9: b.c = CH_HASH;
				10: b.c = CH_COMMA;
				11: b.c = digit_ch();
				default: b.c = 8'($urandom_range(0, 255));
			endcase
			b.e = $urandom_range(0, 7) == 0;
			line_q = {line_q, b};
		end
		case ($urandom_range(0, 3))
			0, 1: put_ch(CH_NL);
			2: end_chunk();
			default: ;
		endcase
	endfunction

	// alt field with comma counts around the point where the count saturates
	function automatic void build_wide_alt();
		put_str("1\t7\t.\tA\t");
		repeat ($urandom_range(253, 258)) put_ch(CH_COMMA);
		put_ch(8'h41);
		put_ch(CH_NL);
	endfunction

	// GT tag and sample subfield placed k colons deep
	function automatic void build_deep_format(int k);
		put_str("1\t5\t.\tA\tC\t.\t.\t.\t");
		repeat (k) put_ch(CH_COLON);
		put_str("GT\t");
		repeat (k) put_ch(CH_COLON);
		put_ch(digit_ch());
		put_ch(sep_ch());
		put_ch(digit_ch());
		put_ch(CH_TAB);
		put_genotype();
		put_ch(CH_NL);
	endfunction

	task automatic random_phase(input logic [16:0] count, input logic gen, input bit deep);
		int first;
		int pick;
		settle();
		write_reg(CFG_SAMPLE_COUNT, count);
		write_reg(CFG_GENOTYPES, {16'b0, gen});
		if (deep) begin
			build_wide_alt();
			send_line();
			build_deep_format($urandom_range(250, 254));
			send_line();
			build_deep_format($urandom_range(255, 258));
			send_line();
		end
		first = sent_items;
		while (sent_items - first < PHASE_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				build_header();
			else if (pick < 12)
				put_ch(CH_NL);
			else if (pick < 22)
				build_noise();
			else if (pick < 23)
				build_deep_format($urandom_range(0, 8));
			else
				build_record();
			send_line();
		end
	endtask

	// ------------------------------------------------------------------
	// directed table
	// ------------------------------------------------------------------

	function automatic void dir_add(logic [7:0] c, logic e, int n, result_t x0, result_t x1);
		dir_row_t row;
		row.c = c;
		row.e = e;
		row.n_exp = n;
		row.x0 = x0;
		row.x1 = x1;
		dir_tab = {dir_tab, row};
	endfunction

	function automatic void dir_text(string s);
		for (int i = 0; i < s.len(); i++)
			dir_add(s[i], 1'b0, -1, '0, '0);
	endfunction

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------

	initial begin : main_seq
		result_t geno_done;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SAMPLE_COUNT;
		cfg_data = '0;
		cfg_samples = 17'd1;
		cfg_gen = 1'b1;
		line_state = MODE_START;
		record_begin();

		// empty line, header with extreme bytes, header cut by chunk end
		dir_add(CH_NL, 1'b0, -1, '0, '0);
		dir_add(CH_HASH, 1'b0, -1, '0, '0);
		dir_add(8'hFF, 1'b0, -1, '0, '0);
		dir_add(CH_NL, 1'b0, -1, '0, '0);
		dir_add(CH_HASH, 1'b0, -1, '0, '0);
		dir_add(8'h00, 1'b1, -1, '0, '0);
		// one record at reset settings: POS 9, two alts, GT 1|2
		dir_text("\t9\t\t\tA,C\t\t\t\tGT\t1|2");
		geno_done = geno_res(0, 4'd1, 4'd2);
		dir_add(CH_NL, 1'b0, 2, geno_done, line_res(32'd9, 2, 1'b1, 1'b1));
		// chunk end on a lone byte: empty summary, no samples seen
		dir_add(8'hFF, 1'b1, 1, line_res(32'd0, 0, 1'b0, 1'b1), '0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			send_beat({dir_tab[i].c, dir_tab[i].e}, 1'b1);
			parse_byte(dir_tab[i].c, dir_tab[i].e);
			if (dir_tab[i].n_exp < 0) begin
				foreach (step_out[k])
					pending_results = {pending_results, step_out[k]};
			end else begin
				if (dir_tab[i].n_exp > 0)
					pending_results = {pending_results, dir_tab[i].x0};
				if (dir_tab[i].n_exp > 1)
					pending_results = {pending_results, dir_tab[i].x1};
			end
		end

		// random phases over several register settings
		random_phase(17'd2, 1'b1, 1'b1);
		random_phase(17'd0, 1'b1, 1'b0);
		random_phase(17'd3, 1'b0, 1'b0);
		random_phase(17'h1FFFF, 1'b1, 1'b0);
		random_phase(17'd65537, 1'b0, 1'b0);
		random_phase(17'd65536, 1'b1, 1'b0);
		random_phase(17'($urandom_range(1, 4)), 1'b1, 1'b0);
		quiet_tail = 1'b1;
		random_phase(17'd1, 1'b1, 1'b0);

		settle();
		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
